@@ src/cbt_pkg.sv @@
`timescale 1ns / 1ps

package cbt_pkg;

    localparam logic [4:0]  QUANTA_MIN  = 5'd8;
    localparam logic [4:0]  QUANTA_LAST = 5'd24;
    localparam logic [31:0] NO_DELTA    = 32'hFFFF_FFFF;
    localparam logic [4:0]  SEG2_DIV    = 5'd3;
    localparam logic [8:0]  SEG2_MUL    = 9'd11;
    localparam logic [4:0]  SJW_LIMIT   = 5'd8;
    localparam logic [2:0]  SJW_MAX     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_START1,
        ST_WAIT1,
        ST_MUL2,
        ST_START2,
        ST_WAIT2,
        ST_EVAL,
        ST_NEXT,
        ST_DONE
    } cbt_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } cbt_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } cbt_div_rsp_t;

    typedef struct packed {
        logic [4:0]  quanta_per_bit;
        logic [28:0] prescaler;
        logic [4:0]  phase_seg1;
        logic [2:0]  phase_seg2;
        logic [2:0]  jump_width;
        logic        no_valid_timing;
    } cbt_res_t;

    typedef struct packed {
        logic [4:0] seg1;
        logic [2:0] seg2;
        logic [2:0] sjw;
    } cbt_seg_t;

    function automatic cbt_seg_t seg_of(input logic [4:0] q);
        logic [4:0] qm1;
        logic [8:0] scaled;
        logic [4:0] s2;
        cbt_seg_t   r;
        qm1    = q - 5'd1;
        // divide by three as (x * 11) >> 5, exact for any 5-bit x
        scaled = {4'd0, qm1} * SEG2_MUL;
        s2     = {1'b0, scaled[8:5]};
        r.seg2 = s2[2:0];
        r.seg1 = qm1 - s2;
        r.sjw  = (r.seg1 >= SJW_LIMIT) ? SJW_MAX : {1'b0, r.seg1[2:1]};
        return r;
    endfunction

endpackage

@@ src/cbt_in_if.sv @@
`timescale 1ns / 1ps

interface cbt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] clock_hz;
    logic [19:0] bitrate_bps;

    modport source (output valid, output clock_hz, output bitrate_bps, input ready);
    modport sink   (input valid, input clock_hz, input bitrate_bps, output ready);
endinterface

@@ src/cbt_out_if.sv @@
`timescale 1ns / 1ps

interface cbt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  quanta_per_bit;
    logic [28:0] prescaler;
    logic [4:0]  phase_seg1;
    logic [2:0]  phase_seg2;
    logic [2:0]  jump_width;
    logic        no_valid_timing;

    modport source (output valid, output quanta_per_bit, output prescaler,
                    output phase_seg1, output phase_seg2, output jump_width,
                    output no_valid_timing, input ready);
    modport sink   (input valid, input quanta_per_bit, input prescaler,
                    input phase_seg1, input phase_seg2, input jump_width,
                    input no_valid_timing, output ready);
endinterface

@@ src/can_bit_timing_select_top.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Item
// cmd      in   clock_hz, bitrate_bps
// res      out  quanta, prescaler, seg1, seg2, jump width, no-valid flag
//
// One item searches up to 17 bit lengths, each with two waits on the shared
// radix-2 divider plus control states, then the result is registered into
// the output register. A length with a zero prescaler skips the second
// division, and an exact match ends the search. A zero bitrate goes
// straight to the result with no search. cmd is ready only when idle.
// The result sits in an output register; a stalled res holds it while the
// next item is computed. Reset clears control state only.

module can_bit_timing_select_top (
    input  logic  clk,
    input  logic  rst_n,
    cbt_in_if.sink    cmd,
    cbt_out_if.source res
);
    import cbt_pkg::*;

    cbt_div_req_t div_req;
    cbt_div_rsp_t div_rsp;
    cbt_res_t     seq_res;
    cbt_res_t     out_reg;
    logic         out_valid_reg, out_valid_next;
    logic         seq_valid;
    logic         seq_ack;

    cbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cbt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cmd.valid),
        .in_ready    (cmd.ready),
        .clock_hz    (cmd.clock_hz),
        .bitrate_bps (cmd.bitrate_bps),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .res_valid   (seq_valid),
        .res_ack     (seq_ack),
        .res         (seq_res)
    );

    assign seq_ack = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seq_valid && seq_ack)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (seq_valid && seq_ack)
            out_reg <= seq_res;
    end

    assign res.valid           = out_valid_reg;
    assign res.quanta_per_bit  = out_reg.quanta_per_bit;
    assign res.prescaler       = out_reg.prescaler;
    assign res.phase_seg1      = out_reg.phase_seg1;
    assign res.phase_seg2      = out_reg.phase_seg2;
    assign res.jump_width      = out_reg.jump_width;
    assign res.no_valid_timing = out_reg.no_valid_timing;

endmodule

@@ src/cbt_div.sv @@
`timescale 1ns / 1ps

module cbt_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbt_pkg::cbt_div_req_t req,
    output cbt_pkg::cbt_div_rsp_t rsp
);
    import cbt_pkg::*;

    logic [31:0] rem_reg,  rem_next;
    logic [31:0] quo_reg,  quo_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [32:0] trial;
    logic [32:0] diff;

    // restoring radix-2, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/cbt_seq.sv @@
`timescale 1ns / 1ps

module cbt_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           clock_hz,
    input  logic [19:0]           bitrate_bps,
    output cbt_pkg::cbt_div_req_t div_req,
    input  cbt_pkg::cbt_div_rsp_t div_rsp,
    output logic                  res_valid,
    input  logic                  res_ack,
    output cbt_pkg::cbt_res_t     res
);
    import cbt_pkg::*;

    cbt_state_t  state_reg, state_next;

    logic [31:0] clk_reg;
    logic [19:0] rate_reg;
    logic [4:0]  q_reg,      q_next;
    logic [31:0] dvs_reg,    dvs_next;
    logic [28:0] presc_reg,  presc_next;
    logic [31:0] got_reg,    got_next;
    logic [4:0]  best_q_reg, best_q_next;
    logic [28:0] best_p_reg, best_p_next;
    logic [31:0] best_d_reg, best_d_next;
    logic        found_reg,  found_next;

    logic        accept;
    logic [24:0] prod1;
    logic [33:0] prod2;
    logic [31:0] delta;
    cbt_seg_t    seg;

    assign accept = in_valid && in_ready;
    assign prod1  = rate_reg * q_reg;
    assign prod2  = presc_reg * q_reg;
    assign delta  = got_reg - {12'd0, rate_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (bitrate_bps == '0) ? ST_DONE : ST_MUL1;
            ST_MUL1:   state_next = ST_START1;
            ST_START1: state_next = ST_WAIT1;
            ST_WAIT1:
                if (div_rsp.done)
                    state_next = (div_rsp.quotient == '0) ? ST_NEXT : ST_MUL2;
            ST_MUL2:   state_next = ST_START2;
            ST_START2: state_next = ST_WAIT2;
            ST_WAIT2:
                if (div_rsp.done)
                    state_next = ST_EVAL;
            ST_EVAL:   state_next = (delta == '0) ? ST_DONE : ST_NEXT;
            ST_NEXT:   state_next = (q_reg == QUANTA_LAST) ? ST_DONE : ST_MUL1;
            ST_DONE:
                if (res_ack)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == ST_IDLE);
        res_valid        = (state_reg == ST_DONE);
        div_req.start    = (state_reg == ST_START1) || (state_reg == ST_START2);
        div_req.dividend = clk_reg;
        div_req.divisor  = dvs_reg;

        q_next      = q_reg;
        dvs_next    = dvs_reg;
        presc_next  = presc_reg;
        got_next    = got_reg;
        best_q_next = best_q_reg;
        best_p_next = best_p_reg;
        best_d_next = best_d_reg;
        found_next  = found_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_next      = QUANTA_MIN;
                best_d_next = NO_DELTA;
                found_next  = 1'b0;
            end
            ST_MUL1: dvs_next = {7'd0, prod1};
            ST_WAIT1:
                if (div_rsp.done)
                    presc_next = div_rsp.quotient[28:0];
            ST_MUL2: dvs_next = prod2[31:0];
            ST_WAIT2:
                if (div_rsp.done)
                    got_next = div_rsp.quotient;
            ST_EVAL:
                if (delta == '0 || !found_reg || delta < best_d_reg)
                begin
                    best_q_next = q_reg;
                    best_p_next = presc_reg;
                    best_d_next = delta;
                    found_next  = 1'b1;
                end
            ST_NEXT: q_next = q_reg + 5'd1;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        seg = seg_of(best_q_reg);
        if (found_reg)
        begin
            res.quanta_per_bit  = best_q_reg;
            res.prescaler       = best_p_reg;
            res.phase_seg1      = seg.seg1;
            res.phase_seg2      = seg.seg2;
            res.jump_width      = seg.sjw;
            res.no_valid_timing = 1'b0;
        end
        else
        begin
            res                 = '0;
            res.no_valid_timing = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            q_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clk_reg  <= clock_hz;
            rate_reg <= bitrate_bps;
        end
        dvs_reg    <= dvs_next;
        presc_reg  <= presc_next;
        got_reg    <= got_next;
        best_q_reg <= best_q_next;
        best_p_reg <= best_p_next;
        best_d_reg <= best_d_next;
    end

endmodule
